>>> hw/rtl/buddy_page_allocator_unit_assert.svh
// Assertion macros for the buddy page allocator
`ifndef BUDDY_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/bpa_pkg.sv
package bpa_pkg;

  localparam int unsigned PAGES_MAX = 4096;
  localparam int unsigned ORDER_MAX = 10;
  localparam int unsigned LISTS     = ORDER_MAX + 1;
  localparam int unsigned PAGE_W    = $clog2(PAGES_MAX);
  localparam int unsigned ORD_W     = 4;
  localparam int unsigned IDX_W     = 36;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned LIST_W    = $clog2(LISTS);

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_BLOCK = 2'd1,
    STAT_BAD_ARG  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_ZONE_FIRST = 2'd0,
    CFG_ZONE_COUNT = 2'd1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_A_FIND, S_A_CLR, S_A_RD, S_A_SPLIT,
    S_F_CHK, S_F_LOOP, S_F_TEST, S_F_END,
    S_R_CHK, S_R_STEP, S_R_BLK,
    S_PUSH1, S_PUSH2, S_REM1, S_REM2,
    S_DONE
  } fsm_e;

  typedef struct packed {
    logic              free;
    logic [ORD_W-1:0]  ord;
    logic [PAGE_W-1:0] nxt;
    logic [PAGE_W-1:0] prv;
  } page_word_t;

  typedef struct packed {
    logic [PAGE_W-1:0] addr;
    logic              en_free;
    logic              en_ord;
    logic              en_nxt;
    logic              en_prv;
    page_word_t        data;
  } page_wr_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [ORD_W-1:0] order;
    logic [IDX_W-1:0] page;
    logic [IDX_W-1:0] range_end;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] block;
  } res_t;

  typedef struct packed {
    logic clearing;
    logic idle;
  } seq_stat_t;

endpackage

>>> hw/rtl/bpa_page_ram.sv
module bpa_page_ram (
  input  logic                          clk_i,
  input  logic                          re_i,
  input  logic [bpa_pkg::PAGE_W-1:0]    raddr_i,
  output bpa_pkg::page_word_t           rdata_o,
  input  bpa_pkg::page_wr_t             wr_i
);

  logic                         mem_free [bpa_pkg::PAGES_MAX];
  logic [bpa_pkg::ORD_W-1:0]    mem_ord  [bpa_pkg::PAGES_MAX];
  logic [bpa_pkg::PAGE_W-1:0]   mem_nxt  [bpa_pkg::PAGES_MAX];
  logic [bpa_pkg::PAGE_W-1:0]   mem_prv  [bpa_pkg::PAGES_MAX];
  bpa_pkg::page_word_t          rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en_free) mem_free[wr_i.addr] <= wr_i.data.free;
    if (wr_i.en_ord)  mem_ord[wr_i.addr]  <= wr_i.data.ord;
    if (wr_i.en_nxt)  mem_nxt[wr_i.addr]  <= wr_i.data.nxt;
    if (wr_i.en_prv)  mem_prv[wr_i.addr]  <= wr_i.data.prv;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q.free <= mem_free[raddr_i];
      rdata_q.ord  <= mem_ord[raddr_i];
      rdata_q.nxt  <= mem_nxt[raddr_i];
      rdata_q.prv  <= mem_prv[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/bpa_seq.sv
module bpa_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bpa_pkg::IDX_W-1:0]     zone_first_i,
  input  logic [bpa_pkg::CNT_W-1:0]     zone_count_i,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  bpa_pkg::req_t                 req_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output bpa_pkg::res_t                 res_o,
  output logic                          ram_re_o,
  output logic [bpa_pkg::PAGE_W-1:0]    ram_raddr_o,
  output bpa_pkg::page_wr_t             ram_wr_o,
  input  bpa_pkg::page_word_t           ram_rdata_i,
  output bpa_pkg::seq_stat_t            stat_o
);

  localparam int unsigned ZW = bpa_pkg::IDX_W + 1;
  localparam int unsigned PW = bpa_pkg::PAGE_W;
  localparam int unsigned OW = bpa_pkg::ORD_W;
  localparam int unsigned LW = bpa_pkg::LIST_W;

  bpa_pkg::fsm_e state_q, state_d, ret_q, ret_d;
  logic [PW-1:0] clr_q, clr_d;
  logic [bpa_pkg::LISTS-1:0] ne_q, ne_d;
  logic [PW-1:0] first_q [bpa_pkg::LISTS];
  logic [PW-1:0] first_d [bpa_pkg::LISTS];
  logic [PW-1:0] last_q  [bpa_pkg::LISTS];
  logic [PW-1:0] last_d  [bpa_pkg::LISTS];

  bpa_pkg::req_t req_q, req_d;
  logic [ZW-1:0] idx_q, idx_d;
  logic [OW-1:0] o_q, o_d, lo_q, lo_d;
  logic [PW-1:0] lp_q, lp_d, nb_q, nb_d;
  logic [bpa_pkg::CNT_W-1:0] rem_q, rem_d;
  logic ltail_q, ltail_d;
  bpa_pkg::res_t res_q, res_d;

  logic [bpa_pkg::CNT_W-1:0] zcnt;
  logic [ZW-1:0] zfirst, zend, bud, bud_lo, rend, rpage;
  logic [OW-1:0] cur, on, ro;
  logic found, hit, af, al;
  logic [LW-1:0] li;

  assign zcnt   = (zone_count_i > bpa_pkg::CNT_W'(bpa_pkg::PAGES_MAX)) ?
                  bpa_pkg::CNT_W'(bpa_pkg::PAGES_MAX) : zone_count_i;
  assign zfirst = ZW'(zone_first_i);
  assign zend   = zfirst + ZW'(zcnt);
  assign rend   = ZW'(req_q.range_end);
  assign rpage  = ZW'(req_q.page);
  assign li     = LW'(lo_q);
  assign on     = o_q - OW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpa_pkg::S_CLEAR;
      ret_q   <= bpa_pkg::S_IDLE;
      clr_q   <= '0;
      ne_q    <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      clr_q   <= clr_d;
      ne_q    <= ne_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    last_q  <= last_d;
    req_q   <= req_d;
    idx_q   <= idx_d;
    o_q     <= o_d;
    lo_q    <= lo_d;
    lp_q    <= lp_d;
    nb_q    <= nb_d;
    rem_q   <= rem_d;
    ltail_q <= ltail_d;
    res_q   <= res_d;
  end

  // smallest non-empty list at or above the requested order
  always_comb begin
    found = 1'b0;
    cur   = '0;
    for (int i = bpa_pkg::ORDER_MAX; i >= 0; i--) begin
      if ((OW'(i) >= req_q.order) && ne_q[i]) begin
        found = 1'b1;
        cur   = OW'(i);
      end
    end
  end

  // largest aligned block that fits in the remaining range
  always_comb begin
    hit = 1'b0;
    ro  = OW'(bpa_pkg::ORDER_MAX);
    for (int i = 0; i < bpa_pkg::ORDER_MAX; i++) begin
      if (!hit && (idx_q[i] || ((rem_q >> (i + 1)) == '0))) begin
        hit = 1'b1;
        ro  = OW'(i);
      end
    end
  end

  always_comb begin
    bud    = idx_q ^ (ZW'(1) << o_q);
    bud_lo = idx_q ^ (ZW'(1) << on);
    af     = first_q[li] == lp_q;
    al     = last_q[li] == lp_q;
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    clr_d   = clr_q;
    ne_d    = ne_q;
    first_d = first_q;
    last_d  = last_q;
    req_d   = req_q;
    idx_d   = idx_q;
    o_d     = o_q;
    lo_d    = lo_q;
    lp_d    = lp_q;
    nb_d    = nb_q;
    rem_d   = rem_q;
    ltail_d = ltail_q;
    res_d   = res_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    ram_re_o    = 1'b0;
    ram_raddr_o = lp_q;
    ram_wr_o    = '0;

    unique case (state_q)
      bpa_pkg::S_CLEAR: begin
        ram_wr_o.addr      = clr_q;
        ram_wr_o.en_free   = 1'b1;
        ram_wr_o.data.free = 1'b0;
        clr_d = clr_q + PW'(1);
        if (clr_q == '1) state_d = bpa_pkg::S_IDLE;
      end
      bpa_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d       = req_i;
          res_d.block = '0;
          res_d.status = bpa_pkg::STAT_OK;
          case (req_i.cmd)
            bpa_pkg::CMD_ALLOC:   state_d = bpa_pkg::S_A_FIND;
            bpa_pkg::CMD_FREE:    state_d = bpa_pkg::S_F_CHK;
            bpa_pkg::CMD_RELEASE: state_d = bpa_pkg::S_R_CHK;
            default: begin
              res_d.status = bpa_pkg::STAT_BAD_ARG;
              state_d = bpa_pkg::S_DONE;
            end
          endcase
        end
      end
      bpa_pkg::S_A_FIND: begin
        if (req_q.order > OW'(bpa_pkg::ORDER_MAX)) begin
          res_d.status = bpa_pkg::STAT_BAD_ARG;
          state_d = bpa_pkg::S_DONE;
        end else if (!found) begin
          res_d.status = bpa_pkg::STAT_NO_BLOCK;
          state_d = bpa_pkg::S_DONE;
        end else begin
          o_d   = cur;
          lo_d  = cur;
          lp_d  = first_q[LW'(cur)];
          idx_d = zfirst + ZW'(first_q[LW'(cur)]);
          state_d = bpa_pkg::S_A_CLR;
        end
      end
      bpa_pkg::S_A_CLR: begin
        ram_wr_o.addr      = lp_q;
        ram_wr_o.en_free   = 1'b1;
        ram_wr_o.data.free = 1'b0;
        state_d = bpa_pkg::S_A_RD;
      end
      bpa_pkg::S_A_RD: begin
        ram_re_o = 1'b1;
        ret_d    = bpa_pkg::S_A_SPLIT;
        state_d  = bpa_pkg::S_REM1;
      end
      bpa_pkg::S_A_SPLIT: begin
        if (o_q == req_q.order) begin
          res_d.block = idx_q[bpa_pkg::IDX_W-1:0];
          state_d = bpa_pkg::S_DONE;
        end else begin
          o_d = on;
          if (bud_lo >= zfirst && bud_lo < zend) begin
            lo_d    = on;
            lp_d    = PW'(bud_lo - zfirst);
            ltail_d = 1'b0;
            ret_d   = bpa_pkg::S_A_SPLIT;
            state_d = bpa_pkg::S_PUSH1;
          end
        end
      end
      bpa_pkg::S_F_CHK: begin
        if (req_q.order > OW'(bpa_pkg::ORDER_MAX) || rpage < zfirst || rpage >= zend) begin
          res_d.status = bpa_pkg::STAT_BAD_ARG;
          state_d = bpa_pkg::S_DONE;
        end else begin
          idx_d = rpage;
          o_d   = req_q.order;
          state_d = bpa_pkg::S_F_LOOP;
        end
      end
      bpa_pkg::S_F_LOOP: begin
        if (o_q >= OW'(bpa_pkg::ORDER_MAX) || bud < zfirst || bud >= zend) begin
          state_d = bpa_pkg::S_F_END;
        end else begin
          lo_d        = o_q;
          lp_d        = PW'(bud - zfirst);
          ram_re_o    = 1'b1;
          ram_raddr_o = PW'(bud - zfirst);
          state_d     = bpa_pkg::S_F_TEST;
        end
      end
      bpa_pkg::S_F_TEST: begin
        if (!ram_rdata_i.free || ram_rdata_i.ord != o_q) begin
          state_d = bpa_pkg::S_F_END;
        end else begin
          o_d = o_q + OW'(1);
          if (bud < idx_q) idx_d = bud;
          ret_d   = bpa_pkg::S_F_LOOP;
          state_d = bpa_pkg::S_REM1;
        end
      end
      bpa_pkg::S_F_END: begin
        lo_d    = o_q;
        lp_d    = PW'(idx_q - zfirst);
        ltail_d = 1'b0;
        ret_d   = bpa_pkg::S_DONE;
        state_d = bpa_pkg::S_PUSH1;
      end
      bpa_pkg::S_R_CHK: begin
        if (rpage < rend) begin
          if (rpage < zfirst || rpage >= zend || rend > zend) begin
            res_d.status = bpa_pkg::STAT_BAD_ARG;
            state_d = bpa_pkg::S_DONE;
          end else begin
            idx_d = rpage;
            state_d = bpa_pkg::S_R_STEP;
          end
        end else begin
          state_d = bpa_pkg::S_DONE;
        end
      end
      bpa_pkg::S_R_STEP: begin
        if (idx_q >= rend) begin
          state_d = bpa_pkg::S_DONE;
        end else begin
          rem_d   = bpa_pkg::CNT_W'(rend - idx_q);
          state_d = bpa_pkg::S_R_BLK;
        end
      end
      bpa_pkg::S_R_BLK: begin
        lo_d    = ro;
        lp_d    = PW'(idx_q - zfirst);
        ltail_d = 1'b1;
        idx_d   = idx_q + (ZW'(1) << ro);
        ret_d   = bpa_pkg::S_R_STEP;
        state_d = bpa_pkg::S_PUSH1;
      end
      bpa_pkg::S_PUSH1: begin
        ram_wr_o.addr      = lp_q;
        ram_wr_o.en_free   = 1'b1;
        ram_wr_o.en_ord    = 1'b1;
        ram_wr_o.data.free = 1'b1;
        ram_wr_o.data.ord  = lo_q;
        if (ltail_q) begin
          nb_d = last_q[li];
          ram_wr_o.en_prv    = ne_q[li];
          ram_wr_o.data.prv  = last_q[li];
          last_d[li] = lp_q;
          if (!ne_q[li]) first_d[li] = lp_q;
        end else begin
          nb_d = first_q[li];
          ram_wr_o.en_nxt    = ne_q[li];
          ram_wr_o.data.nxt  = first_q[li];
          first_d[li] = lp_q;
          if (!ne_q[li]) last_d[li] = lp_q;
        end
        ne_d[li] = 1'b1;
        state_d = ne_q[li] ? bpa_pkg::S_PUSH2 : ret_q;
      end
      bpa_pkg::S_PUSH2: begin
        // link the old end of the list back to the new entry
        ram_wr_o.addr     = nb_q;
        ram_wr_o.en_nxt   = ltail_q;
        ram_wr_o.en_prv   = !ltail_q;
        ram_wr_o.data.nxt = lp_q;
        ram_wr_o.data.prv = lp_q;
        state_d = ret_q;
      end
      bpa_pkg::S_REM1: begin
        if (!ne_q[li]) begin
          state_d = ret_q;
        end else if (af && al) begin
          ne_d[li] = 1'b0;
          state_d  = ret_q;
        end else begin
          if (af) begin
            first_d[li] = ram_rdata_i.nxt;
          end else begin
            ram_wr_o.addr     = ram_rdata_i.prv;
            ram_wr_o.en_nxt   = 1'b1;
            ram_wr_o.data.nxt = ram_rdata_i.nxt;
          end
          if (al) last_d[li] = ram_rdata_i.prv;
          state_d = al ? ret_q : bpa_pkg::S_REM2;
        end
      end
      bpa_pkg::S_REM2: begin
        ram_wr_o.addr     = ram_rdata_i.nxt;
        ram_wr_o.en_prv   = 1'b1;
        ram_wr_o.data.prv = ram_rdata_i.prv;
        state_d = ret_q;
      end
      bpa_pkg::S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = bpa_pkg::S_IDLE;
      end
      default: state_d = bpa_pkg::S_IDLE;
    endcase
  end

  assign res_o          = res_q;
  assign stat_o.clearing = state_q == bpa_pkg::S_CLEAR;
  assign stat_o.idle     = state_q == bpa_pkg::S_IDLE;

endmodule

>>> hw/rtl/buddy_page_allocator_unit.sv
// Buddy page allocator: one command in, one status/page result out.
// Allocate takes the head of the smallest non-empty list at or above the order and
// splits it down; free merges with free buddies of equal order in the zone; release
// carves a range into the largest aligned blocks. One command at a time: the block is
// ready for the next in the cycle after the result enters the output register.
// Reset empties every list; a clearing pass then marks every page busy before the
// first command is taken.
module buddy_page_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // order[3:0], page_index[39:4], range_end[75:40]
  input  logic [1:0]  s_axis_tuser,   // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // block_page[35:0]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [35:0] cfg_data_i
);

  logic [bpa_pkg::IDX_W-1:0] zone_first_q;
  logic [bpa_pkg::CNT_W-1:0] zone_count_q;

  bpa_pkg::req_t      req;
  bpa_pkg::res_t      res, out_q;
  logic               res_valid, res_ready, out_valid_q;
  logic               ram_re, ram_we;
  logic [bpa_pkg::PAGE_W-1:0] ram_raddr;
  bpa_pkg::page_wr_t  ram_wr;
  bpa_pkg::page_word_t ram_rdata;
  bpa_pkg::seq_stat_t seq_stat;

  // Configuration writes are always taken; unknown indexes drop.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_first_q <= '0;
      zone_count_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bpa_pkg::CFG_ZONE_FIRST: zone_first_q <= cfg_data_i;
        bpa_pkg::CFG_ZONE_COUNT: zone_count_q <= cfg_data_i[bpa_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the input transfer.
  assign req.cmd       = s_axis_tuser;
  assign req.order     = s_axis_tdata[3:0];
  assign req.page      = s_axis_tdata[39:4];
  assign req.range_end = s_axis_tdata[75:40];

  bpa_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .zone_first_i (zone_first_q),
    .zone_count_i (zone_count_q),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .req_i        (req),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_wr_o     (ram_wr),
    .ram_rdata_i  (ram_rdata),
    .stat_o       (seq_stat)
  );

  bpa_page_ram u_ram (
    .clk_i   (clk_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata),
    .wr_i    (ram_wr)
  );

  // Output register: hold the result until the downstream transfer.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_q.block};
  assign m_axis_tuser  = out_q.status;

  // Any write lane active on the page memory.
  assign ram_we = ram_wr.en_free || ram_wr.en_ord || ram_wr.en_nxt || ram_wr.en_prv;

`include "buddy_page_allocator_unit_assert.svh"

  `BPA_ASSERT_NOW(a_no_take_clear, seq_stat.clearing, !s_axis_tready, "input taken while clearing")
  `BPA_ASSERT_NOW(a_ready_idle, s_axis_tready, seq_stat.idle, "ready outside idle")
  `BPA_ASSERT_NEXT(a_busy_after, s_axis_tvalid && s_axis_tready, !s_axis_tready, "sequencer not busy")
  `BPA_ASSERT_NOW(a_rw_apart, ram_re, !ram_we, "read and write together")
  `BPA_ASSERT_NOW(a_block_zero, m_axis_tvalid && m_axis_tuser != bpa_pkg::STAT_OK, m_axis_tdata == '0, "page set on error")

endmodule

>>> tb/buddy_page_allocator_unit_tb.sv
module buddy_page_allocator_unit_tb;

  // Command code the block does not know; must answer with a bad argument
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  // Register index beyond the defined registers; writes to it are ignored
  localparam logic [1:0] CFG_UNUSED  = 2'd3;
  // Cycles without any transfer before the run is declared hung: covers the
  // clearing pass after reset plus the worst command and the longest stalls
  localparam int unsigned HANG_LIMIT = 20000;
  localparam longint unsigned IDX_MASK = 64'hF_FFFF_FFFF;

  typedef struct {
    bpa_pkg::status_e          status;
    logic [bpa_pkg::IDX_W-1:0] block;
  } alloc_result_t;

  typedef struct {
    logic [bpa_pkg::PAGE_W-1:0] off;
    logic [bpa_pkg::ORD_W-1:0]  ord;
  } live_block_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;   // order[3:0], page_index[39:4], range_end[75:40]
  logic [1:0]  s_axis_tuser = '0;   // command[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // block_page[35:0]
  logic [1:0]  m_axis_tuser;        // status[1:0]
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [35:0] cfg_data_i = '0;

  buddy_page_allocator_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  // ---------------------------------------------------------------------
  // Shadow allocator: page stores, free lists and zone registers
  // ---------------------------------------------------------------------
  bit                         pg_is_free [bpa_pkg::PAGES_MAX];
  bit [bpa_pkg::ORD_W-1:0]    page_ord   [bpa_pkg::PAGES_MAX];
  bit [bpa_pkg::PAGE_W-1:0]   page_nxt   [bpa_pkg::PAGES_MAX];
  bit [bpa_pkg::PAGE_W-1:0]   page_prv   [bpa_pkg::PAGES_MAX];
  bit [bpa_pkg::PAGE_W-1:0]   lst_first  [bpa_pkg::LISTS];
  bit [bpa_pkg::PAGE_W-1:0]   list_tail  [bpa_pkg::LISTS];
  bit                         list_used  [bpa_pkg::LISTS];
  longint unsigned            zone_base;
  longint unsigned            zone_size;

  bpa_pkg::req_t     req_q[$];        // commands waiting for the driver
  alloc_result_t     result_q[$];     // results owed by the block, oldest first
  live_block_t       live_q[$];       // blocks handed out and not yet freed
  int unsigned       fail_cnt;
  bit                no_idle;

  function automatic longint unsigned zone_end();
    return zone_base + ((zone_size > bpa_pkg::PAGES_MAX) ? bpa_pkg::PAGES_MAX : zone_size);
  endfunction

  function automatic void list_add_head(int unsigned o, bit [bpa_pkg::PAGE_W-1:0] p);
    if (list_used[o]) begin
      page_prv[lst_first[o]] = p;
      page_nxt[p] = lst_first[o];
      lst_first[o] = p;
    end else begin
      lst_first[o] = p;
      list_tail[o] = p;
      list_used[o] = 1'b1;
    end
  endfunction

  function automatic void list_append(int unsigned o, bit [bpa_pkg::PAGE_W-1:0] p);
    if (list_used[o]) begin
      page_nxt[list_tail[o]] = p;
      page_prv[p] = list_tail[o];
      list_tail[o] = p;
    end else begin
      lst_first[o] = p;
      list_tail[o] = p;
      list_used[o] = 1'b1;
    end
  endfunction

  function automatic void list_unlink(int unsigned o, bit [bpa_pkg::PAGE_W-1:0] p);
    bit at_head;
    bit at_tail;
    at_head = (lst_first[o] == p);
    at_tail = (list_tail[o] == p);
    if (!list_used[o]) return;
    if (at_head && at_tail) begin
      list_used[o] = 1'b0;
      return;
    end
    if (at_head) lst_first[o] = page_nxt[p];
    else page_nxt[page_prv[p]] = page_nxt[p];
    if (at_tail) list_tail[o] = page_prv[p];
    else page_prv[page_nxt[p]] = page_prv[p];
  endfunction

  // Apply one command to the shadow stores and return the owed result;
  // a successful allocation also records the block as live.
  function automatic alloc_result_t buddy_step(bpa_pkg::req_t r);
    alloc_result_t   res;
    longint unsigned first;
    longint unsigned zend;
    longint unsigned pg;
    longint unsigned rend;
    longint unsigned idx;
    longint unsigned bud;
    int unsigned     cur;
    int unsigned     o;
    bit [bpa_pkg::PAGE_W-1:0] p;
    live_block_t     lb;
    first = zone_base;
    zend  = zone_end();
    pg    = r.page;
    rend  = r.range_end;
    res.status = bpa_pkg::STAT_OK;
    res.block  = '0;
    case (r.cmd)
      bpa_pkg::CMD_ALLOC: begin
        if (r.order > bpa_pkg::ORDER_MAX) begin
          res.status = bpa_pkg::STAT_BAD_ARG;
        end else begin
          cur = r.order;
          while (cur <= bpa_pkg::ORDER_MAX && !list_used[cur]) cur++;
          if (cur > bpa_pkg::ORDER_MAX) begin
            res.status = bpa_pkg::STAT_NO_BLOCK;
          end else begin
            p = lst_first[cur];
            idx = first + p;
            pg_is_free[p] = 1'b0;
            list_unlink(cur, p);
            // Split down to the asked order; buddies go to their list heads
            while (cur != r.order) begin
              cur--;
              bud = idx ^ (64'd1 << cur);
              if (bud >= first && bud < zend) begin
                page_ord[bud - first]   = cur;
                pg_is_free[bud - first] = 1'b1;
                list_add_head(cur, bud - first);
              end
            end
            res.block = idx & IDX_MASK;
            lb.off = p;
            lb.ord = r.order;
            live_q.push_back(lb);
          end
        end
      end
      bpa_pkg::CMD_FREE: begin
        if (r.order > bpa_pkg::ORDER_MAX || pg < first || pg >= zend) begin
          res.status = bpa_pkg::STAT_BAD_ARG;
        end else begin
          idx = pg;
          o = r.order;
          // Merge upward while the buddy is free, in the zone and equal order
          while (o < bpa_pkg::ORDER_MAX) begin
            bud = idx ^ (64'd1 << o);
            if (bud < first || bud >= zend) break;
            if (!pg_is_free[bud - first] || page_ord[bud - first] != o) break;
            list_unlink(o, bud - first);
            o++;
            if (bud < idx) idx = bud;
          end
          page_ord[idx - first]   = o;
          pg_is_free[idx - first] = 1'b1;
          list_add_head(o, idx - first);
        end
      end
      bpa_pkg::CMD_RELEASE: begin
        if (pg < rend) begin
          if (pg < first || pg >= zend || rend > zend) begin
            res.status = bpa_pkg::STAT_BAD_ARG;
          end else begin
            // Carve the range into the largest aligned blocks that fit
            while (pg < rend) begin
              for (o = 0; o < bpa_pkg::ORDER_MAX; o++) begin
                if (pg[o]) break;
                if (pg + (64'd2 << o) > rend) break;
              end
              page_ord[pg - first]   = o;
              pg_is_free[pg - first] = 1'b1;
              list_append(o, pg - first);
              pg += 64'd1 << o;
            end
          end
        end
      end
      default: res.status = bpa_pkg::STAT_BAD_ARG;
    endcase
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: feed commands from req_q, predict on each accepted transfer
  // ---------------------------------------------------------------------
  int unsigned   s_gap;
  bpa_pkg::req_t cur_req;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      s_gap         <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) result_q.push_back(buddy_step(cur_req));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (s_gap > 0) begin
          s_gap         <= s_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          s_axis_tdata  <= {4'b0, cur_req.range_end, cur_req.page, cur_req.order};
          s_axis_tuser  <= cur_req.cmd;
          s_axis_tvalid <= 1'b1;
          s_gap         <= pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: stall the result side at random, check each transfer
  // ---------------------------------------------------------------------
  int unsigned m_stall;

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want;
    int unsigned   g;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      m_stall       <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d block=%h", $time,
                   m_axis_tuser, m_axis_tdata[35:0]);
          fail_cnt++;
        end else begin
          want = result_q.pop_front();
          if (m_axis_tuser !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d", $time,
                     want.status, m_axis_tuser);
            fail_cnt++;
          end
          if (m_axis_tdata[35:0] !== want.block) begin
            $display("%0t: block_page mismatch: expected %h actual %h", $time,
                     want.block, m_axis_tdata[35:0]);
            fail_cnt++;
          end
        end
        g = pick_gap();
        m_stall       <= g;
        m_axis_tready <= (g == 0);
      end else if (m_stall > 0) begin
        m_stall       <= m_stall - 1;
        m_axis_tready <= (m_stall == 1);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no channel makes progress for too long
  int unsigned quiet_cycles;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  int unsigned next_fresh;   // lowest zone offset never handed to a release

  task automatic push_req(logic [1:0] cmd, logic [3:0] ord, longint unsigned pg,
                          longint unsigned rend);
    bpa_pkg::req_t r;
    r.cmd       = cmd;
    r.order     = ord;
    r.page      = pg & IDX_MASK;
    r.range_end = rend & IDX_MASK;
    while (req_q.size() >= 4) @(posedge clk_i);
    req_q.push_back(r);
  endtask

  // Hold until every command is taken and every result has come back;
  // sample at the falling edge so the driver's updates have settled
  task automatic drain();
    while (req_q.size() != 0 || s_axis_tvalid || result_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [35:0] val);
    @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      bpa_pkg::CFG_ZONE_FIRST: zone_base = val;
      bpa_pkg::CFG_ZONE_COUNT: zone_size = val[bpa_pkg::CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_zone(longint unsigned first, longint unsigned cnt);
    drain();
    write_reg(bpa_pkg::CFG_ZONE_FIRST, first);
    write_reg(bpa_pkg::CFG_ZONE_COUNT, cnt);
  endtask

  function automatic logic [3:0] rand_order();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 3);
    if (r < 96) return $urandom_range(0, bpa_pkg::ORDER_MAX);
    return $urandom_range(bpa_pkg::ORDER_MAX + 1, 15);
  endfunction

  // Malformed or harmless commands: none of them touches the stores
  task automatic push_noise();
    longint unsigned zend;
    longint unsigned pg;
    zend = zone_end();
    pg = {$urandom, $urandom} & IDX_MASK;
    case ($urandom_range(0, 5))
      0: push_req(CMD_UNKNOWN, $urandom, pg, {$urandom, $urandom});
      1: push_req(bpa_pkg::CMD_FREE, $urandom_range(bpa_pkg::ORDER_MAX + 1, 15), pg,
                  {$urandom, $urandom});
      2: push_req(bpa_pkg::CMD_ALLOC, $urandom_range(bpa_pkg::ORDER_MAX + 1, 15), pg,
                  {$urandom, $urandom});
      3: push_req(bpa_pkg::CMD_RELEASE, $urandom, pg, pg - $urandom_range(0, 100));
      4: if (zend < IDX_MASK) push_req(bpa_pkg::CMD_FREE, $urandom_range(0, bpa_pkg::ORDER_MAX),
                                       zend + $urandom_range(0, 3), 0);
         else push_req(CMD_UNKNOWN, 0, pg, 0);
      default:
        if (zend < IDX_MASK - 1) begin
          if ($urandom_range(0, 1)) push_req(bpa_pkg::CMD_RELEASE, 0, zone_base, zend + 1);
          else push_req(bpa_pkg::CMD_RELEASE, 0, zend, zend + 2);
        end else begin
          push_req(CMD_UNKNOWN, $urandom, pg, pg);
        end
    endcase
  endtask

  // Mostly allocate and free pairs, some fresh releases, the rest noise; only noise with safe_only
  task automatic run_random(int unsigned n, bit safe_only);
    int unsigned     r;
    int unsigned     k;
    int unsigned     lim;
    longint unsigned stop;
    live_block_t     lb;
    lim = (zone_size > bpa_pkg::PAGES_MAX) ? bpa_pkg::PAGES_MAX : zone_size;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (safe_only) begin
        push_noise();
      end else if (r < 45) begin
        push_req(bpa_pkg::CMD_ALLOC, rand_order(), {$urandom, $urandom}, {$urandom, $urandom});
      end else if (r < 85 && live_q.size() > 0) begin
        k = $urandom_range(0, live_q.size() - 1);
        lb = live_q[k];
        // Blocks that now fall outside the zone stay busy for good
        if (lb.off < lim) live_q.delete(k);
        push_req(bpa_pkg::CMD_FREE, lb.ord, zone_base + lb.off, {$urandom, $urandom});
      end else if (r < 92 && next_fresh < lim) begin
        stop = next_fresh + $urandom_range(1, 300);
        if (stop > lim) stop = lim;
        push_req(bpa_pkg::CMD_RELEASE, $urandom, zone_base + next_fresh, zone_base + stop);
        next_fresh = stop;
      end else begin
        push_noise();
      end
      if (i % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    fail_cnt   = 0;
    zone_base  = 0;
    zone_size  = 0;
    next_fresh = 0;
    no_idle    = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Small zone at page zero: directed corner cases first
    set_zone(0, 64);
    push_req(bpa_pkg::CMD_RELEASE, 0, 0, 5);
    push_req(bpa_pkg::CMD_ALLOC, 15, 0, 0);
    push_req(bpa_pkg::CMD_FREE, 11, 0, 0);
    push_req(bpa_pkg::CMD_FREE, 0, 64, 0);
    push_req(bpa_pkg::CMD_RELEASE, 0, 60, 70);
    push_req(bpa_pkg::CMD_RELEASE, 0, 70, 71);
    push_req(bpa_pkg::CMD_RELEASE, 0, 10, 3);
    push_req(bpa_pkg::CMD_RELEASE, 15, IDX_MASK, 0);
    push_req(CMD_UNKNOWN, 15, IDX_MASK, IDX_MASK);
    push_req(bpa_pkg::CMD_ALLOC, bpa_pkg::ORDER_MAX, 0, 0);
    push_req(bpa_pkg::CMD_ALLOC, 0, 0, 0);
    push_req(bpa_pkg::CMD_ALLOC, 1, 0, 0);
    push_req(bpa_pkg::CMD_ALLOC, 0, 0, 0);
    push_req(bpa_pkg::CMD_RELEASE, 0, 5, 64);
    push_req(bpa_pkg::CMD_ALLOC, 5, 0, 0);
    push_req(bpa_pkg::CMD_ALLOC, 7, 0, 0);
    next_fresh = 64;
    drain();
    while (live_q.size() > 0) begin
      live_block_t lb;
      lb = live_q.pop_front();
      push_req(bpa_pkg::CMD_FREE, lb.ord, lb.off, 0);
    end
    run_random(300, 1'b0);

    // Highest aligned zone start, page count above depth saturates
    set_zone(36'hF_FFFF_FC00, 13'h1FFF);
    write_reg(CFG_UNUSED, '1);
    run_random(900, 1'b0);

    // Empty zone: allocations still draw on the lists, frees are refused
    set_zone(36'd5120, 0);
    run_random(100, 1'b0);

    // Odd-sized zone: splits and merges stop at the zone end
    set_zone(36'd2048, 1000);
    run_random(600, 1'b0);

    // Unaligned top start: only commands that leave the stores alone
    set_zone(IDX_MASK, bpa_pkg::PAGES_MAX);
    run_random(60, 1'b1);

    drain();
    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0 && result_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> buddy_page_allocator_unit.f
+incdir+hw/rtl
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_page_ram.sv
hw/rtl/bpa_seq.sv
hw/rtl/buddy_page_allocator_unit.sv
tb/buddy_page_allocator_unit_tb.sv
